@@ hdl/key_hold_autoshift_table_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hold-to-shift key table
// Concurrent property shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef KEY_HOLD_AUTOSHIFT_TABLE_ASSERT_SVH
`define KEY_HOLD_AUTOSHIFT_TABLE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define KHAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("key table assertion failed");

// Check a delayed consequent of an antecedent
`define KHAT_ASSERT_LAT2(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error("key table latency assertion failed");

`endif

@@ hdl/khat_pkg.sv @@
// ----------------------------------------------------------------------------
// khat_pkg
// Types, codes and constants shared by the hold-to-shift key table.
// ----------------------------------------------------------------------------
package khat_pkg;

    // Matrix defaults and fixed field widths
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 16;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 4;
    localparam int CODE_W   = 16;
    localparam int STAMP_W  = 16;

    localparam logic [STAMP_W-1:0] HOLD_TIMEOUT_RST = 16'd175;

    // HID usages of the eligible key set
    localparam logic [CODE_W-1:0] USAGE_1    = 16'h001E;
    localparam logic [CODE_W-1:0] USAGE_0    = 16'h0027;
    localparam logic [CODE_W-1:0] USAGE_MINS = 16'h002D;
    localparam logic [CODE_W-1:0] USAGE_EQL  = 16'h002E;
    localparam logic [CODE_W-1:0] USAGE_LBRC = 16'h002F;
    localparam logic [CODE_W-1:0] USAGE_RBRC = 16'h0030;
    localparam logic [CODE_W-1:0] USAGE_NUHS = 16'h0032;
    localparam logic [CODE_W-1:0] USAGE_GRV  = 16'h0035;
    localparam logic [CODE_W-1:0] USAGE_F1   = 16'h003A;
    localparam logic [CODE_W-1:0] USAGE_F12  = 16'h0045;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_TICK    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        VERD_PASS     = 2'd0,
        VERD_CONSUMED = 2'd1,
        VERD_PLAIN    = 2'd2,
        VERD_SHIFTED  = 2'd3
    } t_verdict;

    // One item as held in the decision stage
    typedef struct packed {
        logic [1:0]         action;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [CODE_W-1:0]  code;
        logic               lower;
        logic               in_range;
        logic [STAMP_W-1:0] now;
    } t_item;

    // Outcome of the decision stage
    typedef struct packed {
        logic              res_valid;
        t_verdict          verdict;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CODE_W-1:0] code;
        logic              set_held;
        logic              clr_held;
    } t_decision;

    function automatic logic is_eligible(input logic [CODE_W-1:0] code);
        logic digit;
        logic fkey;
        digit = (code >= USAGE_1) && (code <= USAGE_0);
        fkey  = (code >= USAGE_F1) && (code <= USAGE_F12);
        return digit || fkey || (code == USAGE_MINS) || (code == USAGE_EQL) ||
               (code == USAGE_NUHS) || (code == USAGE_LBRC) ||
               (code == USAGE_RBRC) || (code == USAGE_GRV);
    endfunction

endpackage

@@ hdl/khat_stamp_ram.sv @@
// ----------------------------------------------------------------------------
// khat_stamp_ram
// Press timestamp memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module khat_stamp_ram
    import khat_pkg::*;
#(
    parameter int DEPTH = ROWS_DEF * COLS_DEF,
    parameter int AW    = $clog2(ROWS_DEF * COLS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [STAMP_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [STAMP_W-1:0] o_rdata
);

    logic [STAMP_W-1:0] r_mem [DEPTH];
    logic [STAMP_W-1:0] r_rdata;

    // Write the stamp of a fresh press
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/khat_decide.sv @@
// ----------------------------------------------------------------------------
// khat_decide
// Verdict logic for one press, release or tick against its table entry.
// ----------------------------------------------------------------------------
module khat_decide
    import khat_pkg::*;
(
    input  t_item              i_item,
    input  logic               i_held,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic [STAMP_W-1:0] i_hold_timeout,
    output t_decision          o_dec
);

    logic [STAMP_W-1:0] elapsed;
    logic               handled;

    // Wrapping time since the press
    assign elapsed = i_item.now - i_stamp;
    assign handled = i_item.in_range && i_item.lower && is_eligible(i_item.code);

    always_comb begin
        o_dec = '0;
        o_dec.verdict = VERD_PASS;
        case (i_item.action)
            ACT_TICK: begin
                // Expire a held entry into a shifted tap
                if (i_held && (elapsed > i_hold_timeout)) begin
                    o_dec.res_valid = 1'b1;
                    o_dec.verdict   = VERD_SHIFTED;
                    o_dec.row       = i_item.row;
                    o_dec.col       = i_item.col;
                    o_dec.clr_held  = 1'b1;
                end
            end
            ACT_PRESS: begin
                o_dec.res_valid = 1'b1;
                if (handled) begin
                    o_dec.verdict  = VERD_CONSUMED;
                    o_dec.set_held = !i_held;
                end
            end
            ACT_RELEASE: begin
                o_dec.res_valid = 1'b1;
                if (handled) begin
                    if (i_held) begin
                        o_dec.verdict  = VERD_PLAIN;
                        o_dec.row      = i_item.row;
                        o_dec.col      = i_item.col;
                        o_dec.code     = i_item.code;
                        o_dec.clr_held = 1'b1;
                    end else begin
                        o_dec.verdict = VERD_CONSUMED;
                    end
                end
            end
            default: begin
                o_dec.res_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/key_hold_autoshift_table.sv @@
// ----------------------------------------------------------------------------
// key_hold_autoshift_table
// Hold-to-shift key table: press stamps, held marks and round-robin expiry.
// ----------------------------------------------------------------------------
// The result strobe is registered behind the decision-stage input register.
// Throughput: 1 item per cycle; busy is low out of reset; receiver cannot stall.
// The stamp memory's registered read sets the two-stage depth; a stamp
// written by the item ahead is forwarded to the item behind it.
// Reset clears held marks, the ms counter and the scan position and loads
// the timeout (175); the stamp memory is not cleared, held marks guard it.
// ----------------------------------------------------------------------------
module key_hold_autoshift_table
    import khat_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [ROW_W-1:0]   i_key_row,
    input  logic [COL_W-1:0]   i_key_col,
    input  logic [CODE_W-1:0]  i_key_code,
    input  logic               i_on_lower_layer,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [STAMP_W-1:0] i_cfg_data,
    output logic               o_strobe,
    output logic [1:0]         o_verdict,
    output logic [ROW_W-1:0]   o_tap_row,
    output logic [COL_W-1:0]   o_tap_col,
    output logic [CODE_W-1:0]  o_tap_key_code
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

    logic               accept;
    logic               is_tick;
    logic               ev_in_range;
    logic [AW-1:0]      ev_idx;
    logic [AW-1:0]      scan_idx;
    logic [AW-1:0]      rd_idx;
    logic [STAMP_W-1:0] ram_rdata;
    logic [STAMP_W-1:0] stamp1;
    logic               stamp_we;
    logic               held1;
    t_item              n_item;
    t_decision          dec;

    logic [STAMP_W-1:0] r_hold_timeout;
    logic [STAMP_W-1:0] r_now;
    logic [RW-1:0]      r_scan_row;
    logic [CW-1:0]      r_scan_col;
    logic [DEPTH-1:0]   r_held;
    logic               r_v1;
    t_item              r_item;
    logic [AW-1:0]      r_idx;
    logic               r_fwd_hit;
    logic [STAMP_W-1:0] r_fwd_stamp;
    logic               r_strobe;
    logic [1:0]         r_verdict;
    logic [ROW_W-1:0]   r_tap_row;
    logic [COL_W-1:0]   r_tap_col;
    logic [CODE_W-1:0]  r_tap_code;

    assign busy        = !i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign is_tick     = (i_action == ACT_TICK);

    // Table index of the event key and of the scan position
    assign ev_in_range = (int'(i_key_row) < ROWS) && (int'(i_key_col) < COLS);
    assign ev_idx      = AW'(int'(i_key_row) * COLS + int'(i_key_col));
    assign scan_idx    = AW'(int'(r_scan_row) * COLS + int'(r_scan_col));
    assign rd_idx      = is_tick ? scan_idx : ev_idx;

    // Build the item for the decision stage
    always_comb begin
        n_item          = '0;
        n_item.action   = i_action;
        n_item.code     = i_key_code;
        n_item.lower    = i_on_lower_layer;
        n_item.in_range = ev_in_range;
        if (is_tick) begin
            n_item.row = ROW_W'(r_scan_row);
            n_item.col = COL_W'(r_scan_col);
            n_item.now = r_now + 1'b1;
        end else begin
            n_item.row = i_key_row;
            n_item.col = i_key_col;
            n_item.now = r_now;
        end
    end

    // Hold the timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_timeout <= HOLD_TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hold_timeout <= i_cfg_data;
        end
    end

    // Advance the ms counter and the column-major scan on each tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (accept && is_tick) begin
            r_now <= r_now + 1'b1;
            if (r_scan_row == RW'(ROWS - 1)) begin
                r_scan_row <= '0;
                if (r_scan_col == CW'(COLS - 1)) begin
                    r_scan_col <= '0;
                end else begin
                    r_scan_col <= r_scan_col + 1'b1;
                end
            end else begin
                r_scan_row <= r_scan_row + 1'b1;
            end
        end
    end

    // Input register of the decision stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_idx       <= rd_idx;
        r_fwd_hit   <= stamp_we && (r_idx == rd_idx);
        r_fwd_stamp <= r_item.now;
    end

    khat_stamp_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (r_idx),
        .i_wdata (r_item.now),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    // Take a stamp written by the item ahead from the bypass
    assign stamp1   = r_fwd_hit ? r_fwd_stamp : ram_rdata;
    assign held1    = r_held[r_idx];
    assign stamp_we = r_v1 && dec.set_held;

    khat_decide u_decide (
        .i_item         (r_item),
        .i_held         (held1),
        .i_stamp        (stamp1),
        .i_hold_timeout (r_hold_timeout),
        .o_dec          (dec)
    );

    // Set or drop the held mark of the decided entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (r_v1 && dec.set_held) begin
            r_held[r_idx] <= 1'b1;
        end else if (r_v1 && dec.clr_held) begin
            r_held[r_idx] <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v1 && dec.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict  <= dec.verdict;
        r_tap_row  <= dec.row;
        r_tap_col  <= dec.col;
        r_tap_code <= dec.code;
    end

    assign o_strobe       = r_strobe;
    assign o_verdict      = r_verdict;
    assign o_tap_row      = r_tap_row;
    assign o_tap_col      = r_tap_col;
    assign o_tap_key_code = r_tap_code;

endmodule

@@ hdl/khat_checker.sv @@
// ----------------------------------------------------------------------------
// khat_checker
// Port-level checks of result timing and result field contents.
// ----------------------------------------------------------------------------
`include "key_hold_autoshift_table_assert.svh"

module khat_checker
    import khat_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_action,
    input logic               o_strobe,
    input logic [1:0]         o_verdict,
    input logic [ROW_W-1:0]   o_tap_row,
    input logic [COL_W-1:0]   o_tap_col,
    input logic [CODE_W-1:0]  o_tap_key_code
);

    logic xfer;
    logic ev_xfer;
    logic quiet_res;
    logic no_tap;

    assign xfer      = start && !busy;
    assign ev_xfer   = xfer && (i_action == ACT_PRESS || i_action == ACT_RELEASE);
    assign quiet_res = o_strobe && (o_verdict == VERD_PASS || o_verdict == VERD_CONSUMED);
    assign no_tap    = (o_tap_row == '0) && (o_tap_col == '0) && (o_tap_key_code == '0);

    // Every press or release transfer gets a result strobe
    `KHAT_ASSERT_LAT2(a_event_result, i_clk, i_rst_n, ev_xfer, o_strobe)

    // No transfer, no result strobe for it
    `KHAT_ASSERT_LAT2(a_no_spurious, i_clk, i_rst_n, !xfer, !o_strobe)

    // Pass-through and consumed results carry no tap
    `KHAT_ASSERT_NOW(a_quiet_fields, i_clk, i_rst_n, quiet_res, no_tap)

    // Shifted taps carry no keycode; the code field is zero
    `KHAT_ASSERT_NOW(a_shift_code, i_clk, i_rst_n, o_strobe && o_verdict == VERD_SHIFTED, o_tap_key_code == '0)

endmodule

bind key_hold_autoshift_table khat_checker u_khat_checker (.*);

@@ test/key_hold_autoshift_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the hold-to-shift key table
// Drives key presses, key releases and millisecond ticks through the start /
// busy command port and mirrors the block in a cycle-free predictor: held
// marks, press times, the ms counter and the round-robin scan. Every strobed
// result is compared field by field against the oldest predicted tap. Covers
// the eligible key set, layer gating, repeated presses and releases, expiry
// at both timeout extremes and a random traffic mix.
// ----------------------------------------------------------------------------
module key_hold_autoshift_table_tb;
    import khat_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         KEY_COUNT    = ROWS_DEF * COLS_DEF;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CFG_SETTLE   = 4;
    localparam int         POOL_SIZE    = 8;

    typedef struct packed {
        t_verdict          verdict;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CODE_W-1:0] code;
    } t_tap_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_action;
    logic [ROW_W-1:0]   i_key_row;
    logic [COL_W-1:0]   i_key_col;
    logic [CODE_W-1:0]  i_key_code;
    logic               i_on_lower_layer;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [STAMP_W-1:0] i_cfg_data;
    logic               o_strobe;
    logic [1:0]         o_verdict;
    logic [ROW_W-1:0]   o_tap_row;
    logic [COL_W-1:0]   o_tap_col;
    logic [CODE_W-1:0]  o_tap_key_code;

    // Mirror of the key table
    bit                 held_keys [KEY_COUNT];
    logic [STAMP_W-1:0] press_time [KEY_COUNT];
    logic [STAMP_W-1:0] ms_count;
    logic [STAMP_W-1:0] hold_limit;
    int                 scan_r;
    int                 scan_c;

    t_tap_report        pending_taps [$];
    int                 fail_count = 0;
    int                 stall_cycles = 0;
    bit                 gaps_on;

    // Key pool for random traffic
    logic [ROW_W-1:0]   pool_row [POOL_SIZE];
    logic [COL_W-1:0]   pool_col [POOL_SIZE];
    logic [CODE_W-1:0]  pool_code [POOL_SIZE];

    always #1 i_clk = ~i_clk;

    key_hold_autoshift_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_key_row       (i_key_row),
        .i_key_col       (i_key_col),
        .i_key_code      (i_key_code),
        .i_on_lower_layer(i_on_lower_layer),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_verdict       (o_verdict),
        .o_tap_row       (o_tap_row),
        .o_tap_col       (o_tap_col),
        .o_tap_key_code  (o_tap_key_code)
    );

    function automatic bit shift_candidate(input logic [CODE_W-1:0] code);
        return code inside {[USAGE_1:USAGE_0], [USAGE_F1:USAGE_F12], USAGE_MINS,
                            USAGE_EQL, USAGE_LBRC, USAGE_RBRC, USAGE_NUHS, USAGE_GRV};
    endfunction

    function automatic logic [CODE_W-1:0] pick_shift_code();
        int k;
        k = $urandom_range(0, 27);
        if (k < 10) begin
            return USAGE_1 + CODE_W'(k);
        end
        if (k < 22) begin
            return USAGE_F1 + CODE_W'(k - 10);
        end
        case (k)
            22:      return USAGE_MINS;
            23:      return USAGE_EQL;
            24:      return USAGE_LBRC;
            25:      return USAGE_RBRC;
            26:      return USAGE_NUHS;
            default: return USAGE_GRV;
        endcase
    endfunction

    function automatic t_tap_report make_tap(input t_verdict v, input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col,
                                             input logic [CODE_W-1:0] code);
        t_tap_report rep;
        rep.verdict = v;
        rep.row     = row;
        rep.col     = col;
        rep.code    = code;
        return rep;
    endfunction

    // Advance the table mirror by one accepted item and queue its tap, if any
    task automatic predict_key_table(input logic [1:0] act, input logic [ROW_W-1:0] row,
                                     input logic [COL_W-1:0] col,
                                     input logic [CODE_W-1:0] code, input logic lower);
        int                 idx;
        logic [STAMP_W-1:0] elapsed;
        case (act)
            ACT_TICK: begin
                ms_count = ms_count + 1'b1;
                idx = scan_r * COLS_DEF + scan_c;
                if (held_keys[idx]) begin
                    elapsed = ms_count - press_time[idx];
                    if (elapsed > hold_limit) begin
                        held_keys[idx]  = 1'b0;
                        press_time[idx] = '0;
                        pending_taps.push_back(make_tap(VERD_SHIFTED, ROW_W'(scan_r),
                                                        COL_W'(scan_c), '0));
                    end
                end
                // Walk down the column, then move to the next one
                scan_r = scan_r + 1;
                if (scan_r >= ROWS_DEF) begin
                    scan_r = 0;
                    scan_c = (scan_c + 1) % COLS_DEF;
                end
            end
            ACT_PRESS, ACT_RELEASE: begin
                idx = int'(row) * COLS_DEF + int'(col);
                if (int'(row) >= ROWS_DEF || int'(col) >= COLS_DEF || !lower ||
                    !shift_candidate(code)) begin
                    pending_taps.push_back(make_tap(VERD_PASS, '0, '0, '0));
                end else if (act == ACT_PRESS) begin
                    if (!held_keys[idx]) begin
                        held_keys[idx]  = 1'b1;
                        press_time[idx] = ms_count;
                    end
                    pending_taps.push_back(make_tap(VERD_CONSUMED, '0, '0, '0));
                end else if (held_keys[idx]) begin
                    held_keys[idx]  = 1'b0;
                    press_time[idx] = '0;
                    pending_taps.push_back(make_tap(VERD_PLAIN, row, col, code));
                end else begin
                    pending_taps.push_back(make_tap(VERD_CONSUMED, '0, '0, '0));
                end
            end
            default: begin
            end
        endcase
    endtask

    // Hold one item on the command port until it transfers
    task automatic send_key_item(input logic [1:0] act, input logic [ROW_W-1:0] row,
                                 input logic [COL_W-1:0] col, input logic [CODE_W-1:0] code,
                                 input logic lower);
        start            <= 1'b1;
        i_action         <= act;
        i_key_row        <= row;
        i_key_col        <= col;
        i_key_code       <= code;
        i_on_lower_layer <= lower;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_key_table(act, row, col, code, lower);
    endtask

    task automatic send_tick();
        send_key_item(ACT_TICK, ROW_W'($urandom_range(0, 7)), COL_W'($urandom_range(0, 15)),
                      CODE_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Drop start for a random gap: mostly none or short, now and then long
    task automatic idle_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        n    = 0;
        if (gaps_on) begin
            if (pick >= 90) begin
                n = $urandom_range(5, 30);
            end else if (pick >= 55) begin
                n = $urandom_range(1, 3);
            end
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Let the block go idle, then transfer a new hold timeout
    task automatic write_hold_timeout(input logic [STAMP_W-1:0] value);
        start <= 1'b0;
        while (pending_taps.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hold_limit = value;
    endtask

    task automatic test_directed_keys();
        gaps_on = 1'b1;
        // Press each class of eligible key at two matrix corners and in between
        send_key_item(ACT_PRESS, 3'd0, 4'd0, USAGE_1, 1'b1);
        send_key_item(ACT_PRESS, 3'd7, 4'd15, USAGE_0, 1'b1);
        send_key_item(ACT_PRESS, 3'd1, 4'd2, USAGE_F1, 1'b1);
        send_key_item(ACT_PRESS, 3'd2, 4'd3, USAGE_F12, 1'b1);
        send_key_item(ACT_PRESS, 3'd3, 4'd4, USAGE_MINS, 1'b1);
        send_key_item(ACT_PRESS, 3'd4, 4'd8, USAGE_EQL, 1'b1);
        send_key_item(ACT_PRESS, 3'd5, 4'd10, USAGE_LBRC, 1'b1);
        send_key_item(ACT_PRESS, 3'd6, 4'd12, USAGE_RBRC, 1'b1);
        send_key_item(ACT_PRESS, 3'd7, 4'd1, USAGE_NUHS, 1'b1);
        send_key_item(ACT_PRESS, 3'd0, 4'd14, USAGE_GRV, 1'b1);
        // Press of a held key keeps its stamp; release taps, second release is eaten
        send_key_item(ACT_PRESS, 3'd0, 4'd0, USAGE_1, 1'b1);
        send_key_item(ACT_RELEASE, 3'd0, 4'd0, USAGE_1, 1'b1);
        send_key_item(ACT_RELEASE, 3'd0, 4'd0, USAGE_1, 1'b1);
        // Codes just outside the set, a high byte set, and the wrong layer
        send_key_item(ACT_PRESS, 3'd1, 4'd1, USAGE_1 - 1'b1, 1'b1);
        send_key_item(ACT_PRESS, 3'd1, 4'd1, USAGE_0 + 1'b1, 1'b1);
        send_key_item(ACT_PRESS, 3'd1, 4'd1, USAGE_F12 + 1'b1, 1'b1);
        send_key_item(ACT_RELEASE, 3'd1, 4'd1, 16'h0031, 1'b1);
        send_key_item(ACT_PRESS, 3'd1, 4'd1, 16'hFF1E, 1'b1);
        send_key_item(ACT_PRESS, 3'd1, 4'd1, 16'hFFFF, 1'b1);
        send_key_item(ACT_PRESS, 3'd5, 4'd5, USAGE_GRV, 1'b0);
        // Unused action and a tick that finds nothing to expire
        send_key_item(ACT_UNUSED, 3'd7, 4'd15, 16'hFFFF, 1'b1);
        send_tick();
        // Release reports its own code, not the one pressed
        send_key_item(ACT_RELEASE, 3'd7, 4'd15, USAGE_0, 1'b1);
        send_key_item(ACT_RELEASE, 3'd1, 4'd2, USAGE_F12, 1'b1);
    endtask

    task automatic test_expiry_zero_timeout();
        write_hold_timeout(16'h0000);
        gaps_on = 1'b1;
        send_key_item(ACT_PRESS, 3'd0, 4'd0, USAGE_F1 + 16'd4, 1'b1);
        send_key_item(ACT_PRESS, 3'd7, 4'd15, USAGE_1 + 16'd3, 1'b1);
        // One full scan expires every held key
        repeat (KEY_COUNT + 4) begin
            send_tick();
            idle_gap();
        end
    endtask

    task automatic test_max_timeout();
        write_hold_timeout(16'hFFFF);
        gaps_on = 1'b0;
        send_key_item(ACT_PRESS, 3'd4, 4'd4, USAGE_F12, 1'b1);
        send_key_item(ACT_PRESS, 3'd5, 4'd0, USAGE_RBRC, 1'b1);
        // Nothing can exceed the largest timeout
        repeat (KEY_COUNT + 4) send_tick();
        send_key_item(ACT_RELEASE, 3'd4, 4'd4, USAGE_F12, 1'b1);
        send_key_item(ACT_RELEASE, 3'd5, 4'd0, USAGE_RBRC, 1'b1);
    endtask

    task automatic run_random_chunk(input int count);
        int kind;
        int k;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_row[i]  = ROW_W'($urandom_range(0, 7));
            pool_col[i]  = COL_W'($urandom_range(0, 15));
            pool_code[i] = pick_shift_code();
        end
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL_SIZE - 1);
            if (kind < 40) begin
                send_tick();
            end else if (kind < 62) begin
                send_key_item(ACT_PRESS, pool_row[k], pool_col[k], pool_code[k], 1'b1);
            end else if (kind < 82) begin
                send_key_item(ACT_RELEASE, pool_row[k], pool_col[k], pool_code[k], 1'b1);
            end else if (kind < 86) begin
                send_key_item(2'($urandom_range(0, 1)), pool_row[k], pool_col[k],
                              pool_code[k], 1'b0);
            end else if (kind < 94) begin
                send_key_item(2'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 7)),
                              COL_W'($urandom_range(0, 15)), CODE_W'($urandom),
                              1'($urandom_range(0, 1)));
            end else begin
                send_key_item(2'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 7)),
                              COL_W'($urandom_range(0, 15)), pick_shift_code(), 1'b1);
            end
            idle_gap();
        end
    endtask

    task automatic test_random_traffic();
        write_hold_timeout(16'd1);
        gaps_on = 1'b0;
        run_random_chunk(26);
        write_hold_timeout(STAMP_W'($urandom_range(2, 300)));
        gaps_on = 1'b1;
        run_random_chunk(26);
        write_hold_timeout(STAMP_W'($urandom));
        run_random_chunk(26);
        write_hold_timeout(HOLD_TIMEOUT_RST);
        run_random_chunk(26);
    endtask

    // Compare every strobed result against the oldest predicted tap
    always @(posedge i_clk) begin : check_taps
        t_tap_report want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_taps.size() == 0) begin
                $error("unexpected result: verdict %0d row %0d col %0d code 0x%04h",
                       o_verdict, o_tap_row, o_tap_col, o_tap_key_code);
                fail_count++;
            end else begin
                want = pending_taps.pop_front();
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, o_verdict);
                    fail_count++;
                end
                if (o_tap_row !== want.row) begin
                    $error("tap_row: expected %0d, actual %0d", want.row, o_tap_row);
                    fail_count++;
                end
                if (o_tap_col !== want.col) begin
                    $error("tap_col: expected %0d, actual %0d", want.col, o_tap_col);
                    fail_count++;
                end
                if (o_tap_key_code !== want.code) begin
                    $error("tap_key_code: expected 0x%04h, actual 0x%04h",
                           want.code, o_tap_key_code);
                    fail_count++;
                end
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && !busy) || o_strobe === 1'b1 ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_action         <= ACT_TICK;
        i_key_row        <= '0;
        i_key_col        <= '0;
        i_key_code       <= '0;
        i_on_lower_layer <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_data       <= '0;
        gaps_on          = 1'b0;
        // Reset the mirror to match the block after reset
        for (int i = 0; i < KEY_COUNT; i++) begin
            held_keys[i]  = 1'b0;
            press_time[i] = '0;
        end
        ms_count   = '0;
        hold_limit = HOLD_TIMEOUT_RST;
        scan_r     = 0;
        scan_c     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_keys();
        test_expiry_zero_timeout();
        test_max_timeout();
        test_random_traffic();

        // Drain outstanding taps, then allow for the pipeline
        start <= 1'b0;
        while (pending_taps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
